// File: hdl/gmd_pkg.sv
// ----------------------------------------------------------------------------
// gmd_pkg: shared types and constants for the grid maze path search
// Field widths, request and status codes, and the controller/datapath link.
// ----------------------------------------------------------------------------
package gmd_pkg;

  localparam int OP_W      = 2;
  localparam int COORD_W   = 6;
  localparam int KIND_W    = 2;
  localparam int INDEX_W   = 12;
  localparam int STATUS_W  = 2;
  localparam int LENGTH_W  = 13;
  localparam int GRID_W    = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WALL  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_OTHER = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  localparam logic [GRID_W-1:0] GRID_RESET = 7'd16;

  // neighbour order: up, down, left, right
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef struct packed {
    logic                latch;
    logic                clear_step;
    logic                push_start;
    logic                first_dir;
    logic                next_dir;
    logic                probe;
    logic                push_nb;
    logic                pop;
    logic                pop_load;
    logic                read_load;
    logic                set_status;
    logic [STATUS_W-1:0] status;
    logic                out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic start_ok;
    logic at_end;
    logic nb_in_grid;
    logic nb_ok;
    logic dir_last;
    logic stack_last;
    logic out_free;
  } dp_stat_t;

endpackage

// File: hdl/gmd_ifs.sv
// ----------------------------------------------------------------------------
// gmd interfaces: request, response and configuration channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface gmd_req_if;
  logic                          valid;
  logic                          ready;
  logic [gmd_pkg::OP_W-1:0]      op;
  logic [gmd_pkg::COORD_W-1:0]   cell_x;
  logic [gmd_pkg::COORD_W-1:0]   cell_y;
  logic [gmd_pkg::KIND_W-1:0]    cell_kind;
  logic [gmd_pkg::COORD_W-1:0]   start_x;
  logic [gmd_pkg::COORD_W-1:0]   start_y;
  logic [gmd_pkg::COORD_W-1:0]   end_x;
  logic [gmd_pkg::COORD_W-1:0]   end_y;
  logic [gmd_pkg::INDEX_W-1:0]   path_index;

  modport source (output valid, op, cell_x, cell_y, cell_kind, start_x, start_y,
                  end_x, end_y, path_index, input ready);
  modport sink   (input valid, op, cell_x, cell_y, cell_kind, start_x, start_y,
                  end_x, end_y, path_index, output ready);
endinterface

interface gmd_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [gmd_pkg::STATUS_W-1:0]  status;
  logic [gmd_pkg::LENGTH_W-1:0]  path_length;
  logic [gmd_pkg::COORD_W-1:0]   path_x;
  logic [gmd_pkg::COORD_W-1:0]   path_y;

  modport source (output valid, status, path_length, path_x, path_y, input ready);
  modport sink   (input valid, status, path_length, path_x, path_y, output ready);
endinterface

interface gmd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gmd_pkg::CFG_IDX_W-1:0] index;
  logic [gmd_pkg::GRID_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/grid_maze_dfs_path.sv
// ----------------------------------------------------------------------------
// grid_maze_dfs_path: depth-first path search over a stored grid maze
// Controller plus datapath; maze, visited map and path stack in block memory.
// ----------------------------------------------------------------------------
// Requests arrive on req, one result per request leaves on rsp, and the
// grid size registers are written on cfg (index 0 width, 1 height; always
// ready). The user must have them taken only while the block is idle;
// the block does not enforce this. One request is worked on at a time;
// req.ready is high only when idle.
//   write cell : maze written as taken, then S_DONE loads the output register
//   read entry : stack read in S_READ, result set in S_READLD, then S_DONE
//   run search : clears all MAX_WIDTH*MAX_HEIGHT visited entries, then probes
//                neighbours (S_PROBE, S_EVAL) and backtracks (S_POP, S_POPLD)
// The output register holds a result until rsp.ready; a stalled receiver
// holds the block in its final state and no further request is taken.
// Reset (rst, synchronous) empties the stack, sets width and height to 16
// and drops rsp.valid; maze cells stay undefined until written.
// ----------------------------------------------------------------------------
module grid_maze_dfs_path #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic      clk,
  input  logic      rst,
  gmd_req_if.sink   req,
  gmd_rsp_if.source rsp,
  gmd_cfg_if.sink   cfg
);

  gmd_pkg::dp_cmd_t  cmd;
  gmd_pkg::dp_stat_t stat;

  gmd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gmd_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .op         (req.op),
    .cell_x     (req.cell_x),
    .cell_y     (req.cell_y),
    .cell_kind  (req.cell_kind),
    .start_x    (req.start_x),
    .start_y    (req.start_y),
    .end_x      (req.end_x),
    .end_y      (req.end_y),
    .path_index (req.path_index),
    .rsp        (rsp),
    .cfg        (cfg)
  );

endmodule

// File: hdl/gmd_ctrl.sv
// ----------------------------------------------------------------------------
// gmd_ctrl: sequencer for the grid maze path search
// Steps the datapath through cell writes, clear, search and path reads.
// ----------------------------------------------------------------------------
module gmd_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  input  logic [gmd_pkg::OP_W-1:0] req_op,
  output logic                     req_ready,
  input  gmd_pkg::dp_stat_t        stat,
  output gmd_pkg::dp_cmd_t         cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_START  = 4'd2;
  localparam logic [3:0] S_TEST   = 4'd3;
  localparam logic [3:0] S_PROBE  = 4'd4;
  localparam logic [3:0] S_EVAL   = 4'd5;
  localparam logic [3:0] S_POP    = 4'd6;
  localparam logic [3:0] S_POPLD  = 4'd7;
  localparam logic [3:0] S_READ   = 4'd8;
  localparam logic [3:0] S_READLD = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch = 1'b1;
          unique case (req_op)
            gmd_pkg::OP_RUN:  state_next = S_CLEAR;
            gmd_pkg::OP_READ: state_next = S_READ;
            gmd_pkg::OP_WRITE, gmd_pkg::OP_NONE: begin
              cmd.set_status = 1'b1;
              cmd.status     = gmd_pkg::ST_OK;
              state_next     = S_DONE;
            end
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = S_START;
      end
      S_START: begin
        if (stat.start_ok) begin
          cmd.push_start = 1'b1;
          state_next     = S_TEST;
        end else begin
          cmd.set_status = 1'b1;
          cmd.status     = gmd_pkg::ST_NONE;
          state_next     = S_DONE;
        end
      end
      S_TEST: begin
        if (stat.at_end) begin
          cmd.set_status = 1'b1;
          cmd.status     = gmd_pkg::ST_FOUND;
          state_next     = S_DONE;
        end else begin
          cmd.first_dir = 1'b1;
          state_next    = S_PROBE;
        end
      end
      S_PROBE: begin
        if (stat.nb_in_grid) begin
          cmd.probe  = 1'b1;
          state_next = S_EVAL;
        end else if (stat.dir_last) begin
          state_next = S_POP;
        end else begin
          cmd.next_dir = 1'b1;
        end
      end
      S_EVAL: begin
        if (stat.nb_ok) begin
          cmd.push_nb = 1'b1;
          state_next  = S_TEST;
        end else if (stat.dir_last) begin
          state_next = S_POP;
        end else begin
          cmd.next_dir = 1'b1;
          state_next   = S_PROBE;
        end
      end
      S_POP: begin
        cmd.pop = 1'b1;
        if (stat.stack_last) begin
          cmd.set_status = 1'b1;
          cmd.status     = gmd_pkg::ST_NONE;
          state_next     = S_DONE;
        end else begin
          state_next = S_POPLD;
        end
      end
      S_POPLD: begin
        cmd.pop_load = 1'b1;
        state_next   = S_TEST;
      end
      S_READ: state_next = S_READLD;
      S_READLD: begin
        cmd.read_load = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hdl/gmd_datapath.sv
// ----------------------------------------------------------------------------
// gmd_datapath: maze, visited map, path stack and result register
// Holds the search position, neighbour probe and the configuration registers.
// ----------------------------------------------------------------------------
module gmd_datapath #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gmd_pkg::dp_cmd_t              cmd,
  output gmd_pkg::dp_stat_t             stat,
  input  logic [gmd_pkg::OP_W-1:0]      op,
  input  logic [gmd_pkg::COORD_W-1:0]   cell_x,
  input  logic [gmd_pkg::COORD_W-1:0]   cell_y,
  input  logic [gmd_pkg::KIND_W-1:0]    cell_kind,
  input  logic [gmd_pkg::COORD_W-1:0]   start_x,
  input  logic [gmd_pkg::COORD_W-1:0]   start_y,
  input  logic [gmd_pkg::COORD_W-1:0]   end_x,
  input  logic [gmd_pkg::COORD_W-1:0]   end_y,
  input  logic [gmd_pkg::INDEX_W-1:0]   path_index,
  gmd_rsp_if.source                     rsp,
  gmd_cfg_if.sink                       cfg
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int CNTW  = $clog2(CELLS + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WDW   = $clog2(MAX_WIDTH + 1);
  localparam int HDW   = $clog2(MAX_HEIGHT + 1);
  localparam int EW    = XW + YW;
  localparam int CW    = gmd_pkg::COORD_W;

  logic [gmd_pkg::GRID_W-1:0]   grid_width;
  logic [gmd_pkg::GRID_W-1:0]   grid_height;
  logic [CW-1:0]                start_x_q;
  logic [CW-1:0]                start_y_q;
  logic [CW-1:0]                end_x_q;
  logic [CW-1:0]                end_y_q;
  logic [gmd_pkg::INDEX_W-1:0]  index_q;
  logic [XW-1:0]                cur_x;
  logic [YW-1:0]                cur_y;
  logic [1:0]                   dir;
  logic [XW-1:0]                nb_x_q;
  logic [YW-1:0]                nb_y_q;
  logic [AW-1:0]                nb_addr_q;
  logic [CNTW-1:0]              count;
  logic [AW-1:0]                clr_addr;
  logic [gmd_pkg::STATUS_W-1:0] res_status;
  logic [CW-1:0]                res_x;
  logic [CW-1:0]                res_y;
  logic                         out_valid;

  logic [gmd_pkg::KIND_W-1:0]   maze [CELLS];
  logic                         visited [CELLS];
  logic [EW-1:0]                stack [CELLS];
  logic [gmd_pkg::KIND_W-1:0]   maze_rd;
  logic                         vis_rd;
  logic [EW-1:0]                stk_rd;

  logic [WDW-1:0]               w_used;
  logic [HDW-1:0]               h_used;
  logic [XW-1:0]                nb_x;
  logic [YW-1:0]                nb_y;
  logic                         nb_in_grid;
  logic [AW-1:0]                nb_addr;
  logic [AW-1:0]                start_addr;
  logic                         maze_we;
  logic [AW-1:0]                maze_wa;
  logic                         vis_we;
  logic [AW-1:0]                vis_wa;
  logic                         vis_wd;
  logic                         stk_we;
  logic [AW-1:0]                stk_wa;
  logic [EW-1:0]                stk_wd;
  logic [AW-1:0]                stk_ra;
  logic [CNTW-1:0]              pop_addr;
  logic                         read_hit;

  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;

  assign w_used = (32'(grid_width) > MAX_WIDTH) ? WDW'(MAX_WIDTH) : WDW'(grid_width);
  assign h_used = (32'(grid_height) > MAX_HEIGHT) ? HDW'(MAX_HEIGHT) : HDW'(grid_height);

  always_comb begin
    nb_x       = cur_x;
    nb_y       = cur_y;
    nb_in_grid = 1'b0;
    unique case (dir)
      gmd_pkg::DIR_UP: begin
        nb_y       = cur_y - YW'(1);
        nb_in_grid = (cur_y != '0);
      end
      gmd_pkg::DIR_DOWN: begin
        nb_y       = cur_y + YW'(1);
        nb_in_grid = ((32'(cur_y) + 1) < 32'(h_used));
      end
      gmd_pkg::DIR_LEFT: begin
        nb_x       = cur_x - XW'(1);
        nb_in_grid = (cur_x != '0);
      end
      gmd_pkg::DIR_RIGHT: begin
        nb_x       = cur_x + XW'(1);
        nb_in_grid = ((32'(cur_x) + 1) < 32'(w_used));
      end
    endcase
  end

  assign nb_addr    = AW'(32'(nb_y) * MAX_WIDTH + 32'(nb_x));
  assign start_addr = AW'(32'(start_y_q) * MAX_WIDTH + 32'(start_x_q));
  assign pop_addr   = count - CNTW'(2);
  assign read_hit   = (32'(index_q) < 32'(count));

  assign stat.clear_last = (clr_addr == AW'(CELLS - 1));
  assign stat.start_ok   = (32'(start_x_q) < 32'(w_used)) && (32'(start_y_q) < 32'(h_used));
  assign stat.at_end     = (32'(cur_x) == 32'(end_x_q)) && (32'(cur_y) == 32'(end_y_q));
  assign stat.nb_in_grid = nb_in_grid;
  assign stat.nb_ok      = ((maze_rd == gmd_pkg::KIND_FREE) || (maze_rd == gmd_pkg::KIND_END))
                           && !vis_rd && (32'(count) < CELLS);
  assign stat.dir_last   = (dir == gmd_pkg::DIR_RIGHT);
  assign stat.stack_last = (count == CNTW'(1));
  assign stat.out_free   = !out_valid || rsp.ready;

  // memory ports
  assign maze_we = cmd.latch && (op == gmd_pkg::OP_WRITE)
                   && (32'(cell_x) < MAX_WIDTH) && (32'(cell_y) < MAX_HEIGHT);
  assign maze_wa = AW'(32'(cell_y) * MAX_WIDTH + 32'(cell_x));

  always_comb begin
    vis_we = 1'b0;
    vis_wa = clr_addr;
    vis_wd = 1'b0;
    priority if (cmd.clear_step) begin
      vis_we = 1'b1;
    end else if (cmd.push_start) begin
      vis_we = 1'b1;
      vis_wa = start_addr;
      vis_wd = 1'b1;
    end else if (cmd.push_nb) begin
      vis_we = 1'b1;
      vis_wa = nb_addr_q;
      vis_wd = 1'b1;
    end
  end

  assign stk_we = cmd.push_start || cmd.push_nb;
  assign stk_wa = cmd.push_start ? '0 : count[AW-1:0];
  assign stk_wd = cmd.push_start ? {XW'(start_x_q), YW'(start_y_q)} : {nb_x_q, nb_y_q};
  assign stk_ra = cmd.pop ? pop_addr[AW-1:0] : AW'(index_q);

  always_ff @(posedge clk) begin
    if (maze_we) maze[maze_wa] <= cell_kind;
    maze_rd <= maze[nb_addr];
  end

  always_ff @(posedge clk) begin
    if (vis_we) visited[vis_wa] <= vis_wd;
    vis_rd <= visited[nb_addr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack[stk_wa] <= stk_wd;
    stk_rd <= stack[stk_ra];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      start_x_q <= start_x;
      start_y_q <= start_y;
      end_x_q   <= end_x;
      end_y_q   <= end_y;
      index_q   <= path_index;
      clr_addr  <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + AW'(1);
    end
    if (cmd.probe) begin
      nb_x_q    <= nb_x;
      nb_y_q    <= nb_y;
      nb_addr_q <= nb_addr;
    end
    if (cmd.push_start) begin
      cur_x <= XW'(start_x_q);
      cur_y <= YW'(start_y_q);
    end else if (cmd.push_nb) begin
      cur_x <= nb_x_q;
      cur_y <= nb_y_q;
    end else if (cmd.pop_load) begin
      cur_x <= stk_rd[EW-1:YW];
      cur_y <= stk_rd[YW-1:0];
    end
    if (cmd.set_status) begin
      res_status <= cmd.status;
      res_x      <= '0;
      res_y      <= '0;
    end else if (cmd.read_load) begin
      res_status <= read_hit ? gmd_pkg::ST_OK : gmd_pkg::ST_NONE;
      res_x      <= read_hit ? CW'(stk_rd[EW-1:YW]) : '0;
      res_y      <= read_hit ? CW'(stk_rd[YW-1:0]) : '0;
    end
    if (cmd.out_load) begin
      rsp.status      <= res_status;
      rsp.path_length <= gmd_pkg::LENGTH_W'(count);
      rsp.path_x      <= res_x;
      rsp.path_y      <= res_y;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= gmd_pkg::GRID_RESET;
      grid_height <= gmd_pkg::GRID_RESET;
      count       <= '0;
      dir         <= gmd_pkg::DIR_UP;
      out_valid   <= 1'b0;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == gmd_pkg::CFG_WIDTH) grid_width <= cfg.data;
        if (cfg.index == gmd_pkg::CFG_HEIGHT) grid_height <= cfg.data;
      end
      priority if (cmd.latch && (op == gmd_pkg::OP_RUN)) begin
        count <= '0;
      end else if (cmd.push_start) begin
        count <= CNTW'(1);
      end else if (cmd.push_nb) begin
        count <= count + CNTW'(1);
      end else if (cmd.pop) begin
        count <= count - CNTW'(1);
      end
      if (cmd.first_dir) begin
        dir <= gmd_pkg::DIR_UP;
      end else if (cmd.next_dir) begin
        dir <= dir + 2'd1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/gmd_checker.sv
// ----------------------------------------------------------------------------
// gmd_checker: port-level checks for the grid maze path search
// Bound to the top level; watches the request and response channels.
// ----------------------------------------------------------------------------
module gmd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             req_valid,
  input logic                             req_ready,
  input logic                             rsp_valid,
  input logic                             rsp_ready,
  input logic [gmd_pkg::STATUS_W-1:0]     rsp_status,
  input logic [gmd_pkg::LENGTH_W-1:0]     rsp_length,
  input logic [gmd_pkg::COORD_W-1:0]      rsp_x,
  input logic [gmd_pkg::COORD_W-1:0]      rsp_y
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while busy");

  a_found_has_path: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == gmd_pkg::ST_FOUND)
    |-> (rsp_length != '0) && (rsp_x == '0) && (rsp_y == '0))
    else $error("path found with empty stack or stray coordinates");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
    && $stable(rsp_length) && $stable(rsp_x) && $stable(rsp_y))
    else $error("response changed while stalled");

endmodule

bind grid_maze_dfs_path gmd_checker u_gmd_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_length (rsp.path_length),
  .rsp_x      (rsp.path_x),
  .rsp_y      (rsp.path_y)
);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for grid_maze_dfs_path
// Loads maze cells, runs depth-first searches and reads back path entries.
// Each accepted request is replayed on a software maze search; every response
// is matched field by field, in order. Grid size is varied between phases,
// including zero, one, the 64 limit and values beyond it.
// ----------------------------------------------------------------------------
module tb;
  import gmd_pkg::*;

  localparam int MAX_W        = 64;
  localparam int MAX_H        = 64;
  localparam int CELLS        = MAX_W * MAX_H;
  localparam int QUIET_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 8;
  localparam int RANDOM_ITEMS = 100;
  localparam int REPORT_CAP   = 100;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic [KIND_W-1:0]  cell_kind;
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [INDEX_W-1:0] path_index;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LENGTH_W-1:0] path_length;
    logic [COORD_W-1:0]  path_x;
    logic [COORD_W-1:0]  path_y;
  } result_t;

  class path_scoreboard;
    logic [KIND_W-1:0]  cells [CELLS];
    bit                 known [CELLS];
    bit                 seen [CELLS];
    logic [COORD_W-1:0] trail_x [CELLS];
    logic [COORD_W-1:0] trail_y [CELLS];
    int unsigned        depth;
    int unsigned        grid_w;
    int unsigned        grid_h;
    int unsigned        errors;
    result_t            expected_q [$];

    function new();
      grid_w = GRID_RESET;
      grid_h = GRID_RESET;
      depth  = 0;
      errors = 0;
      foreach (known[i]) known[i] = 1'b0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [GRID_W-1:0] val);
      if (idx == CFG_WIDTH) grid_w = val;
      else if (idx == CFG_HEIGHT) grid_h = val;
    endfunction

    function int unsigned used_w();
      return (grid_w > MAX_W) ? MAX_W : grid_w;
    endfunction

    function int unsigned used_h();
      return (grid_h > MAX_H) ? MAX_H : grid_h;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // depth-first walk; leaves the path on the trail when the end is reached
    function bit trace_path(int sx, int sy, int ex, int ey);
      int w, h, cx, cy, nx, ny, idx;
      bit moved;
      logic [1:0] dir;
      w = used_w();
      h = used_h();
      depth = 0;
      foreach (seen[i]) seen[i] = 1'b0;
      if (w == 0 || h == 0 || sx >= w || sy >= h) return 1'b0;
      trail_x[0] = sx;
      trail_y[0] = sy;
      depth = 1;
      seen[sy * MAX_W + sx] = 1'b1;
      while (depth > 0) begin
        cx = trail_x[depth-1];
        cy = trail_y[depth-1];
        if (cx == ex && cy == ey) return 1'b1;
        moved = 1'b0;
        for (int d = 0; d < 4 && !moved; d++) begin
          dir = d;
          nx = cx;
          ny = cy;
          case (dir)
            DIR_UP:   ny = cy - 1;
            DIR_DOWN: ny = cy + 1;
            DIR_LEFT: nx = cx - 1;
            default:  nx = cx + 1;
          endcase
          if (nx < 0 || ny < 0 || nx >= w || ny >= h) continue;
          idx = ny * MAX_W + nx;
          if (seen[idx] || !(cells[idx] == KIND_FREE || cells[idx] == KIND_END)) continue;
          if (depth >= CELLS) continue;
          trail_x[depth] = nx;
          trail_y[depth] = ny;
          depth++;
          seen[idx] = 1'b1;
          moved = 1'b1;
        end
        if (!moved) depth--;
      end
      return 1'b0;
    endfunction

    function void note_request(request_t r);
      result_t e;
      e = '0;
      e.status = ST_OK;
      case (r.op)
        OP_WRITE: begin
          cells[{r.cell_y, r.cell_x}] = r.cell_kind;
          known[{r.cell_y, r.cell_x}] = 1'b1;
        end
        OP_RUN: begin
          e.status = trace_path(r.start_x, r.start_y, r.end_x, r.end_y) ? ST_FOUND : ST_NONE;
        end
        OP_READ: begin
          if (r.path_index < depth) begin
            e.path_x = trail_x[r.path_index];
            e.path_y = trail_y[r.path_index];
          end else begin
            e.status = ST_NONE;
          end
        end
        default: ;
      endcase
      e.path_length = depth;
      expected_q.push_back(e);
    endfunction

    function void compare(string field, logic [LENGTH_W-1:0] want, logic [LENGTH_W-1:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: response with no request outstanding, expected none, got %h",
                   $time, got);
        return;
      end
      e = expected_q.pop_front();
      compare("status", e.status, got.status);
      compare("path_length", e.path_length, got.path_length);
      compare("path_x", e.path_x, got.path_x);
      compare("path_y", e.path_y, got.path_y);
    endfunction
  endclass

  logic clk;
  logic rst;

  gmd_req_if req();
  gmd_rsp_if rsp();
  gmd_cfg_if cfg();

  grid_maze_dfs_path #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  path_scoreboard sb;
  int unsigned    send_idle_pct;
  int unsigned    stall_pct;
  int unsigned    requests_sent;
  bit             hold_off_wanted;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // response side: random stalls, plus one long hold-off on demand
  initial begin
    int unsigned held;
    held = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_wanted && held < HOLD_CYCLES) begin
        rsp.ready = 1'b0;
        held++;
      end else begin
        if (hold_off_wanted) begin
          hold_off_wanted = 1'b0;
          held = 0;
        end
        rsp.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && rsp.valid === 1'b1 && rsp.ready === 1'b1)
      sb.check_result({rsp.status, rsp.path_length, rsp.path_x, rsp.path_y});
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((req.valid === 1'b1 && req.ready === 1'b1) ||
          (rsp.valid === 1'b1 && rsp.ready === 1'b1) ||
          (cfg.valid === 1'b1 && cfg.ready === 1'b1))
        quiet = 0;
      else
        quiet++;
    end
    $display("[grid_maze_dfs_path] ERROR");
    $finish;
  end

  function void set_idle(int unsigned mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 58; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 58; end
      default: begin send_idle_pct = 37; stall_pct = 37; end
    endcase
  endfunction

  function request_t random_request();
    request_t r;
    r.op         = $urandom;
    r.cell_x     = $urandom;
    r.cell_y     = $urandom;
    r.cell_kind  = $urandom;
    r.start_x    = $urandom;
    r.start_y    = $urandom;
    r.end_x      = $urandom;
    r.end_y      = $urandom;
    r.path_index = $urandom;
    return r;
  endfunction

  function logic [KIND_W-1:0] random_kind();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 55) return KIND_FREE;
    if (p < 78) return KIND_WALL;
    if (p < 90) return KIND_END;
    return KIND_OTHER;
  endfunction

  task automatic send_request(request_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req.valid = 1'b0;
    end
    @(negedge clk);
    req.op         = item.op;
    req.cell_x     = item.cell_x;
    req.cell_y     = item.cell_y;
    req.cell_kind  = item.cell_kind;
    req.start_x    = item.start_x;
    req.start_y    = item.start_y;
    req.end_x      = item.end_x;
    req.end_y      = item.end_y;
    req.path_index = item.path_index;
    req.valid      = 1'b1;
    do @(posedge clk); while (req.ready !== 1'b1);
    sb.note_request(item);
    requests_sent++;
  endtask

  task automatic write_cell(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [KIND_W-1:0] kind);
    request_t r;
    r = random_request();
    r.op        = OP_WRITE;
    r.cell_x    = x;
    r.cell_y    = y;
    r.cell_kind = kind;
    send_request(r);
  endtask

  task automatic start_search(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                              logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey);
    request_t r;
    r = random_request();
    r.op      = OP_RUN;
    r.start_x = sx;
    r.start_y = sy;
    r.end_x   = ex;
    r.end_y   = ey;
    send_request(r);
  endtask

  task automatic read_entry(logic [INDEX_W-1:0] k);
    request_t r;
    r = random_request();
    r.op         = OP_READ;
    r.path_index = k;
    send_request(r);
  endtask

  task automatic send_unused_op();
    request_t r;
    r = random_request();
    r.op = OP_NONE;
    send_request(r);
  endtask

  // every cell a search may look at must hold a written kind
  task automatic prepare_grid();
    for (int y = 0; y < sb.used_h(); y++)
      for (int x = 0; x < sb.used_w(); x++)
        if (!sb.known[y * MAX_W + x]) write_cell(x, y, random_kind());
  endtask

  task automatic set_grid(int unsigned w, int unsigned h);
    logic [GRID_W-1:0] vals [2];
    vals[0] = w;
    vals[1] = h;
    @(negedge clk);
    req.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    for (int i = 0; i < 2; i++) begin
      @(negedge clk);
      cfg.index = (i == 0) ? CFG_WIDTH : CFG_HEIGHT;
      cfg.data  = vals[i];
      cfg.valid = 1'b1;
      do @(posedge clk); while (cfg.ready !== 1'b1);
      sb.set_register(cfg.index, cfg.data);
    end
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  initial begin
    int unsigned base, scenario, uw, uh;
    logic [COORD_W-1:0] sx, sy, ex, ey;
    sb = new();
    requests_sent   = 0;
    hold_off_wanted = 1'b0;
    set_idle(0);
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.op         = OP_WRITE;
    req.cell_x     = '0;
    req.cell_y     = '0;
    req.cell_kind  = KIND_FREE;
    req.start_x    = '0;
    req.start_y    = '0;
    req.end_x      = '0;
    req.end_y      = '0;
    req.path_index = '0;
    cfg.valid      = 1'b0;
    cfg.index      = CFG_WIDTH;
    cfg.data       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty stack, unused op, start off the reset-sized grid, zero-sized grids
    set_idle(3);
    read_entry(0);
    send_unused_op();
    start_search(16, 0, 0, 0);
    start_search(0, 16, 0, 0);
    set_grid(0, 5);
    start_search(0, 0, 1, 1);
    set_grid(3, 0);
    start_search(0, 0, 1, 1);

    // 3x3: wall, other and end cells; path detours round the other cell
    set_grid(3, 3);
    write_cell(0, 0, KIND_FREE);
    write_cell(1, 0, KIND_WALL);
    write_cell(2, 0, KIND_END);
    write_cell(0, 1, KIND_FREE);
    write_cell(1, 1, KIND_OTHER);
    write_cell(2, 1, KIND_FREE);
    write_cell(0, 2, KIND_FREE);
    write_cell(1, 2, KIND_FREE);
    write_cell(2, 2, KIND_FREE);
    start_search(0, 0, 0, 0);
    start_search(0, 0, 2, 0);
    read_entry(0);
    read_entry(6);
    read_entry(7);
    read_entry(4095);
    start_search(0, 0, 5, 5);
    read_entry(0);
    start_search(3, 0, 0, 0);

    // extremes of the grid registers
    set_idle(0);
    set_grid(64, 1);
    for (int x = 0; x < MAX_W; x++) write_cell(x, 0, KIND_FREE);
    start_search(0, 0, 63, 0);
    read_entry(63);
    read_entry(64);
    set_grid(1, 64);
    for (int y = 0; y < MAX_H; y++) write_cell(0, y, KIND_FREE);
    start_search(0, 63, 0, 0);
    read_entry(0);
    set_grid(127, 2);
    prepare_grid();
    start_search(63, 1, 0, 0);
    read_entry(1);
    set_grid(2, 100);
    prepare_grid();
    start_search(1, 63, 0, 0);
    read_entry(2);

    // random mazes: small grids, a few cells changed between searches
    base = requests_sent;
    scenario = 0;
    while (requests_sent - base < RANDOM_ITEMS) begin
      set_idle(scenario / 3);
      if (scenario % 5 == 0)
        set_grid(($urandom_range(9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 9),
                 ($urandom_range(9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 9));
      if (scenario == 2) hold_off_wanted = 1'b1;
      prepare_grid();
      uw = sb.used_w();
      uh = sb.used_h();
      repeat ($urandom_range(0, 4)) begin
        if (uw > 0 && uh > 0)
          write_cell($urandom_range(uw - 1), $urandom_range(uh - 1), random_kind());
        else
          write_cell($urandom_range(63), $urandom_range(63), random_kind());
      end
      if (uw > 0 && uh > 0 && $urandom_range(9) != 0) begin
        sx = $urandom_range(uw - 1);
        sy = $urandom_range(uh - 1);
      end else begin
        sx = $urandom_range(63);
        sy = $urandom_range(63);
      end
      if (uw > 0 && uh > 0 && $urandom_range(99) < 85) begin
        ex = $urandom_range(uw - 1);
        ey = $urandom_range(uh - 1);
      end else begin
        ex = $urandom_range(63);
        ey = $urandom_range(63);
      end
      start_search(sx, sy, ex, ey);
      repeat ($urandom_range(1, 4)) begin
        if (sb.depth > 0 && $urandom_range(4) != 0)
          read_entry($urandom_range(sb.depth - 1));
        else
          read_entry($urandom_range(4095));
      end
      if ($urandom_range(9) == 0) send_unused_op();
      scenario++;
    end

    // full 64x64 open grid: the walk snakes through every cell
    set_idle(0);
    set_grid(64, 64);
    for (int y = 0; y < MAX_H; y++)
      for (int x = 0; x < MAX_W; x++)
        write_cell(x, y, KIND_FREE);
    start_search(0, 0, 63, 0);
    read_entry(4095);
    read_entry(0);
    read_entry(2000);

    @(negedge clk);
    req.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE * 4) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[grid_maze_dfs_path] OK");
    end else begin
      $display("[grid_maze_dfs_path] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/gmd_pkg.sv
hdl/gmd_ifs.sv
hdl/gmd_ctrl.sv
hdl/gmd_datapath.sv
hdl/grid_maze_dfs_path.sv
hdl/gmd_checker.sv
tb/sv/tb.sv
